>>> hw/rtl/vgrt_pkg.sv
package vgrt_pkg;

    // Item kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RAY   = 1'b1;

    localparam int DIR_BITS = 14;
    localparam int T_BITS   = 41;

    // Walker states
    typedef enum logic [2:0] {
        WK_IDLE,
        WK_DIV,
        WK_CLEAR,
        WK_READ,
        WK_TEST,
        WK_DONE
    } wk_state_t;

    // Command passed from the front to the back part
    typedef struct packed {
        logic        func;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [5:0]  cell_z;
        logic        cell_solid;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] origin_z;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] dir_z;
    } vgrt_cmd_t;

    // One result beat
    typedef struct packed {
        logic       hit;
        logic [5:0] hit_x;
        logic [5:0] hit_y;
        logic [5:0] hit_z;
        logic [1:0] normal_x;
        logic [1:0] normal_y;
        logic [1:0] normal_z;
    } vgrt_res_t;

endpackage

>>> hw/rtl/vgrt_cmd_fifo.sv
module vgrt_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vgrt_pkg::vgrt_cmd_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output vgrt_pkg::vgrt_cmd_t  pop_data,
    output logic                 empty
);
    import vgrt_pkg::*;

    vgrt_cmd_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Store incoming beat
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end
endmodule

>>> hw/rtl/vgrt_walker.sv
module vgrt_walker #(
    parameter int GRID_BITS_X   = 6,
    parameter int GRID_BITS_Y   = 6,
    parameter int GRID_BITS_Z   = 6,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  vgrt_pkg::vgrt_cmd_t  cmd,
    output logic                 cmd_take,
    input  logic [15:0]          max_distance,
    output logic                 res_valid,
    output vgrt_pkg::vgrt_res_t  res,
    input  logic                 res_take,
    output logic                 clearing
);
    import vgrt_pkg::*;

    localparam int CELL_BITS = GRID_BITS_X + GRID_BITS_Y + GRID_BITS_Z;
    localparam int DEPTH     = 1 << CELL_BITS;
    localparam int NUM_W     = FRACTION_BITS + DIR_BITS + 1;
    localparam int QB        = NUM_W;
    localparam int CB        = 17;
    localparam logic [T_BITS-1:0] T_INF = {1'b1, {(T_BITS-1){1'b0}}};
    localparam logic [FRACTION_BITS:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};

    logic occ_mem [DEPTH];

    wk_state_t state_reg, state_next;
    logic [CELL_BITS-1:0] clr_reg;
    logic [CELL_BITS-1:0] rd_idx;
    logic                 rd_bit_reg;

    logic signed [CB-1:0] cell_reg [3];
    logic [1:0]           step_reg [3];
    logic [T_BITS-1:0]    tnext_reg [3];
    logic [T_BITS-1:0]    tdelta_reg [3];
    logic [1:0]           last_reg [3];
    logic [T_BITS-1:0]    dist_reg;
    vgrt_res_t            res_reg;
    logic                 res_valid_reg;

    // Shared restoring divider: axis 0..2, tnext then tdelta
    logic [2:0]        div_job_reg;
    logic [5:0]        div_bit_reg;
    logic [QB-1:0]     div_num_reg;
    logic [QB-1:0]     div_quo_reg;
    logic [15:0]       div_rem_reg;
    logic [15:0]       div_den;
    logic [16:0]       div_trial;
    logic [1:0]        div_axis;
    logic              div_second;

    logic [15:0] dir_w [3];
    logic [15:0] org_w [3];
    logic [FRACTION_BITS-1:0] frac_w [3];
    logic [15:0] abs_d [3];

    assign dir_w[0] = cmd.dir_x;
    assign dir_w[1] = cmd.dir_y;
    assign dir_w[2] = cmd.dir_z;
    assign org_w[0] = cmd.origin_x;
    assign org_w[1] = cmd.origin_y;
    assign org_w[2] = cmd.origin_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            frac_w[k] = org_w[k][FRACTION_BITS-1:0];
            abs_d[k]  = dir_w[k][15] ? (~dir_w[k] + 16'd1) : dir_w[k];
        end
    end

    assign div_axis   = div_job_reg[2:1];
    assign div_second = div_job_reg[0];
    assign div_den    = abs_d[div_axis];
    assign div_trial  = {div_rem_reg, div_num_reg[QB-1]} - {1'b0, div_den};

    // Numerator for the given job
    function automatic logic [QB-1:0] job_num(input logic sec, input logic neg,
                                               input logic [FRACTION_BITS-1:0] f);
        logic [FRACTION_BITS:0] n;
        begin
            if (sec)
                n = ONE_FIX;
            else if (neg)
                n = {1'b0, f};
            else
                n = ONE_FIX - {1'b0, f};
            job_num = {n, {DIR_BITS{1'b0}}};
        end
    endfunction

    // Axis selection: a tie never picks X, a Y/Z tie picks Z
    logic [1:0] ax;
    always_comb
    begin
        if (tnext_reg[0] < tnext_reg[1])
            ax = (tnext_reg[0] < tnext_reg[2]) ? 2'd0 : 2'd2;
        else
            ax = (tnext_reg[1] < tnext_reg[2]) ? 2'd1 : 2'd2;
    end

    logic in_grid;
    assign in_grid = (cell_reg[0] >= 0) && (cell_reg[0] < (CB'(1) <<< GRID_BITS_X)) &&
                     (cell_reg[1] >= 0) && (cell_reg[1] < (CB'(1) <<< GRID_BITS_Y)) &&
                     (cell_reg[2] >= 0) && (cell_reg[2] < (CB'(1) <<< GRID_BITS_Z));

    assign rd_idx = {cell_reg[2][GRID_BITS_Z-1:0], cell_reg[1][GRID_BITS_Y-1:0],
                     cell_reg[0][GRID_BITS_X-1:0]};

    logic wr_ok;
    assign wr_ok = (32'(cmd.cell_x) < (32'd1 << GRID_BITS_X)) &&
                   (32'(cmd.cell_y) < (32'd1 << GRID_BITS_Y)) &&
                   (32'(cmd.cell_z) < (32'd1 << GRID_BITS_Z));

    // Occupancy memory: clear sweep, voxel writes, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == WK_CLEAR)
            occ_mem[clr_reg] <= 1'b0;
        else if (state_reg == WK_IDLE && cmd_valid && cmd.func == FUNC_WRITE && wr_ok)
            occ_mem[{GRID_BITS_Z'(cmd.cell_z), GRID_BITS_Y'(cmd.cell_y),
                     GRID_BITS_X'(cmd.cell_x)}] <= cmd.cell_solid;
        rd_bit_reg <= occ_mem[rd_idx];
    end

    // Next state and handshake
    always_comb
    begin
        state_next = state_reg;
        cmd_take   = 1'b0;
        case (state_reg)
            WK_CLEAR: if (clr_reg == {CELL_BITS{1'b1}}) state_next = WK_IDLE;
            WK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.func == FUNC_WRITE)
                        cmd_take = 1'b1;
                    else if (!res_valid_reg)
                        state_next = WK_DIV;
                end
            end
            WK_DIV:
                if (div_bit_reg == 6'd0 && div_job_reg == 3'd5) state_next = WK_READ;
            WK_READ: state_next = WK_TEST;
            WK_TEST:
            begin
                if (dist_reg > T_BITS'(max_distance) || !in_grid || rd_bit_reg)
                    state_next = WK_DONE;
                else
                    state_next = WK_READ;
            end
            WK_DONE:
            begin
                cmd_take   = 1'b1;
                state_next = WK_IDLE;
            end
            default: state_next = WK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WK_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == WK_CLEAR)
                clr_reg <= clr_reg + CELL_BITS'(1);
            if (state_reg == WK_DONE)
                res_valid_reg <= 1'b1;
            else if (res_take)
                res_valid_reg <= 1'b0;
        end
    end

    // Datapath: setup, divide, walk
    always_ff @(posedge clk)
    begin
        case (state_reg)
            WK_IDLE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cell_reg[k] <= CB'($signed(org_w[k]) >>> FRACTION_BITS);
                    last_reg[k] <= 2'd0;
                    if (dir_w[k] == 16'd0)
                    begin
                        step_reg[k]   <= 2'b00;
                        tnext_reg[k]  <= T_INF;
                        tdelta_reg[k] <= T_INF;
                    end
                    else
                        step_reg[k] <= dir_w[k][15] ? 2'b11 : 2'b01;
                end
                dist_reg    <= '0;
                div_job_reg <= 3'd0;
                div_bit_reg <= 6'(QB - 1);
                div_rem_reg <= '0;
                div_num_reg <= job_num(1'b0, dir_w[0][15], frac_w[0]);
            end
            WK_DIV:
            begin
                div_quo_reg <= {div_quo_reg[QB-2:0], !div_trial[16]};
                if (div_bit_reg == 6'd0)
                begin
                    if (div_den != 16'd0)
                    begin
                        if (div_second)
                            tdelta_reg[div_axis] <= T_BITS'({div_quo_reg[QB-2:0],
                                                            !div_trial[16]});
                        else
                            tnext_reg[div_axis] <= T_BITS'({div_quo_reg[QB-2:0],
                                                           !div_trial[16]});
                    end
                    div_job_reg <= div_job_reg + 3'd1;
                    div_bit_reg <= 6'(QB - 1);
                    div_rem_reg <= '0;
                    div_num_reg <= job_num(!div_second,
                                           dir_w[div_second ? div_axis + 2'd1 : div_axis][15],
                                           frac_w[div_second ? div_axis + 2'd1 : div_axis]);
                end
                else
                begin
                    if (div_trial[16])
                        div_rem_reg <= {div_rem_reg[14:0], div_num_reg[QB-1]};
                    else
                        div_rem_reg <= div_trial[15:0];
                    div_num_reg <= {div_num_reg[QB-2:0], 1'b0};
                    div_bit_reg <= div_bit_reg - 6'd1;
                end
            end
            WK_TEST:
            begin
                if (dist_reg <= T_BITS'(max_distance) && in_grid && rd_bit_reg)
                    res_reg <= '{hit: 1'b1,
                                 hit_x: cell_reg[0][5:0],
                                 hit_y: cell_reg[1][5:0],
                                 hit_z: cell_reg[2][5:0],
                                 normal_x: 2'd0 - last_reg[0],
                                 normal_y: 2'd0 - last_reg[1],
                                 normal_z: 2'd0 - last_reg[2]};
                else
                    res_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k) == ax)
                    begin
                        cell_reg[k]  <= cell_reg[k] + CB'($signed(step_reg[k]));
                        tnext_reg[k] <= tnext_reg[k] + tdelta_reg[k];
                        last_reg[k]  <= step_reg[k];
                    end
                    else
                        last_reg[k] <= 2'd0;
                end
                dist_reg <= tnext_reg[ax];
            end
            default: ;
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign clearing  = (state_reg == WK_CLEAR);
endmodule

>>> hw/rtl/voxel_grid_ray_traversal.sv
// Voxel occupancy grid with a ray caster.
// Input channel: push/full. func 0 writes one voxel (cell_x/y/z, cell_solid)
// and gives no result; func 1 casts a ray from origin_x/y/z (8 fraction bits)
// along dir_x/y/z (14 fraction bits).
// Result channel: empty/pop, one beat per ray: hit, hit_x/y/z, normal_x/y/z.
// Configuration: cfg_valid/cfg_ready write max_distance, taken at any time.
// A two-entry command queue decouples acceptance from the walker.
// A ray runs 6 serial divides of FRACTION_BITS+15 quotient bits each, then a read
// state and a test state per voxel visited, and a done state to finish.
// A voxel write is done by the walker from its idle state.
// The walker handles one item at a time: a ray holds it until its done state,
// so rays run one after another, never overlapped.
// After reset the occupancy memory is swept clear, one voxel per cycle, over all
// 2^(GRID_BITS_X+GRID_BITS_Y+GRID_BITS_Z) voxels; full stays high meanwhile.
// With the result unread, the walker holds the next ray and the queue fills,
// after which full goes high; writes ahead of that ray still pass through.
module voxel_grid_ray_traversal #(
    parameter int GRID_BITS_X   = 6,
    parameter int GRID_BITS_Y   = 6,
    parameter int GRID_BITS_Z   = 6,
    parameter int FRACTION_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [5:0]  cell_z,
    input  logic        cell_solid,
    input  logic [15:0] origin_x,
    input  logic [15:0] origin_y,
    input  logic [15:0] origin_z,
    input  logic [15:0] dir_x,
    input  logic [15:0] dir_y,
    input  logic [15:0] dir_z,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic        hit,
    output logic [5:0]  hit_x,
    output logic [5:0]  hit_y,
    output logic [5:0]  hit_z,
    output logic [1:0]  normal_x,
    output logic [1:0]  normal_y,
    output logic [1:0]  normal_z
);
    import vgrt_pkg::*;

    vgrt_cmd_t   in_cmd, q_cmd;
    vgrt_res_t   res;
    logic        q_full, q_empty, q_pop, res_valid, clearing;
    logic [15:0] max_dist_reg;

    // Hold max_distance
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_dist_reg <= 16'd1536;
        else if (cfg_valid)
            max_dist_reg <= cfg_data;
    end

    assign in_cmd = '{func: func, cell_x: cell_x, cell_y: cell_y, cell_z: cell_z,
                      cell_solid: cell_solid, origin_x: origin_x, origin_y: origin_y,
                      origin_z: origin_z, dir_x: dir_x, dir_y: dir_y, dir_z: dir_z};

    assign full = q_full || clearing;

    vgrt_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && !clearing),
        .push_data (in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .empty     (q_empty)
    );

    vgrt_walker #(
        .GRID_BITS_X   (GRID_BITS_X),
        .GRID_BITS_Y   (GRID_BITS_Y),
        .GRID_BITS_Z   (GRID_BITS_Z),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!q_empty),
        .cmd          (q_cmd),
        .cmd_take     (q_pop),
        .max_distance (max_dist_reg),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (pop),
        .clearing     (clearing)
    );

    assign empty    = !res_valid;
    assign hit      = res.hit;
    assign hit_x    = res.hit_x;
    assign hit_y    = res.hit_y;
    assign hit_z    = res.hit_z;
    assign normal_x = res.normal_x;
    assign normal_y = res.normal_y;
    assign normal_z = res.normal_z;

    // A miss carries all-zero fields (checked here on hit_x, normal_x and normal_z)
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hit) |-> (hit_x == 6'd0 && normal_x == 2'd0 && normal_z == 2'd0))
        else $error("miss with nonzero fields");

    // Nothing accepted during the clearing sweep
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("input open during clear");

    // A hit normal has at most one nonzero axis
    a_normal_one: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && hit) |-> $onehot0({normal_x != 2'd0, normal_y != 2'd0, normal_z != 2'd0}))
        else $error("normal on more than one axis");
endmodule
